// ===== rtl/ffza_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ffza_pkg;

    // table and address geometry
    localparam int ZONE_ENTRIES = 64;
    localparam int ADDR_BITS    = 32;
    localparam int IDX_W        = $clog2(ZONE_ENTRIES);
    localparam int CNT_W        = $clog2(ZONE_ENTRIES + 1);

    // fixed field widths
    localparam int DATA_W = 32;
    localparam int NEED_W = 62;
    localparam int SUM_W  = 64;
    localparam int GAP_W  = 8;
    localparam int STAT_W = 4;
    localparam int CFG_W  = 2;

    localparam logic [DATA_W-1:0] ADDR_MASK = (ADDR_BITS >= DATA_W) ? {DATA_W{1'b1}} :
        DATA_W'((64'd1 << ADDR_BITS) - 64'd1);

    // register indexes
    localparam logic [CFG_W-1:0] CFG_HEAP_START = 2'd0;
    localparam logic [CFG_W-1:0] CFG_HEAP_END   = 2'd1;
    localparam logic [CFG_W-1:0] CFG_DESC_GAP   = 2'd2;

    localparam logic [GAP_W-1:0] GAP_RESET = 8'd24;

    // result codes
    localparam logic [STAT_W-1:0] ST_NEW        = 4'd0;
    localparam logic [STAT_W-1:0] ST_REUSED     = 4'd1;
    localparam logic [STAT_W-1:0] ST_BAD_SIZE   = 4'd2;
    localparam logic [STAT_W-1:0] ST_BAD_COUNT  = 4'd3;
    localparam logic [STAT_W-1:0] ST_EMPTY      = 4'd4;
    localparam logic [STAT_W-1:0] ST_NO_MEMORY  = 4'd5;
    localparam logic [STAT_W-1:0] ST_TABLE_FULL = 4'd6;
    localparam logic [STAT_W-1:0] ST_FREED      = 4'd7;
    localparam logic [STAT_W-1:0] ST_NO_MATCH   = 4'd8;

    typedef struct packed {
        logic              in_ready;
        logic              load_req;
        logic              load_need;
        logic              scan_start;
        logic              scan_step;
        logic              commit_hit;
        logic              commit_new;
        logic              emit;
        logic [STAT_W-1:0] code;
    } ffza_cmd_t;

    typedef struct packed {
        logic is_free;
        logic bad_size;
        logic bad_count;
        logic empty_req;
        logic addr_zero;
        logic table_empty;
        logic table_full;
        logic hit;
        logic last;
        logic fits;
        logic slot_free;
    } ffza_stat_t;

endpackage

`default_nettype wire

// ===== rtl/ffza_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ffza_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ffza_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ffza_ctrl
    import ffza_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire ffza_stat_t stat,
    output ffza_cmd_t       cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_CARVE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.load_need = 1'b1;
                if (stat.is_free)
                begin
                    if (stat.addr_zero || stat.table_empty)
                    begin
                        if (stat.slot_free)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.code   = ST_NO_MATCH;
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_SCAN;
                    end
                end
                else if (stat.bad_size || stat.bad_count || stat.empty_req)
                begin
                    if (stat.slot_free)
                    begin
                        cmd.emit   = 1'b1;
                        state_next = S_IDLE;
                        priority if (stat.bad_size)
                            cmd.code = ST_BAD_SIZE;
                        else if (stat.bad_count)
                            cmd.code = ST_BAD_COUNT;
                        else
                            cmd.code = ST_EMPTY;
                    end
                end
                else if (stat.table_empty)
                begin
                    state_next = S_CARVE;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.hit)
                begin
                    if (stat.slot_free)
                    begin
                        cmd.emit       = 1'b1;
                        cmd.commit_hit = 1'b1;
                        cmd.code       = stat.is_free ? ST_FREED : ST_REUSED;
                        state_next     = S_IDLE;
                    end
                end
                else if (stat.last)
                begin
                    if (!stat.is_free)
                    begin
                        state_next = S_CARVE;
                    end
                    else if (stat.slot_free)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.code   = ST_NO_MATCH;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_CARVE:
            begin
                if (stat.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                    priority if (!stat.fits)
                        cmd.code = ST_NO_MEMORY;
                    else if (stat.table_full)
                        cmd.code = ST_TABLE_FULL;
                    else
                    begin
                        cmd.code       = ST_NEW;
                        cmd.commit_new = 1'b1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ffza_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ffza_dp
    import ffza_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ffza_cmd_t         cmd,
    output ffza_stat_t             stat,
    input  wire logic              cfg_we,
    input  wire logic [CFG_W-1:0]  cfg_index,
    input  wire logic [DATA_W-1:0] cfg_data,
    input  wire logic              func,
    input  wire logic [DATA_W-1:0] element_size,
    input  wire logic [DATA_W-1:0] element_count,
    input  wire logic [DATA_W-1:0] zone_address,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [DATA_W-1:0]      granted_address,
    output logic [STAT_W-1:0]      status
);

    // configuration
    logic [DATA_W-1:0] heap_start_reg, heap_start_next;
    logic [DATA_W-1:0] heap_end_reg, heap_end_next;
    logic [GAP_W-1:0]  gap_reg, gap_next;

    // allocator state
    logic [DATA_W-1:0]       bump_reg, bump_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [ZONE_ENTRIES-1:0] in_use_reg, in_use_next;

    // request and scan
    logic              req_func_reg;
    logic [DATA_W-1:0] req_size_reg, req_count_reg, req_addr_reg;
    logic [NEED_W-1:0] need_reg, need_next;
    logic [IDX_W-1:0]  chk_idx_reg, chk_idx_next;
    logic [CNT_W-1:0]  left_reg, left_next;
    logic [CNT_W-1:0]  count_m1;

    // result
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] granted_reg, granted_next;
    logic [STAT_W-1:0] status_reg, status_next;

    // memories
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [DATA_W-1:0] rd_base, rd_len;
    logic [SUM_W-1:0]  carve_sum;

    assign count_m1  = count_reg - CNT_W'(1);
    assign rd_en     = cmd.scan_start | cmd.scan_step;
    assign rd_addr   = cmd.scan_start ? count_m1[IDX_W-1:0] : (chk_idx_reg - IDX_W'(1));
    assign need_next = NEED_W'(req_size_reg[DATA_W-2:0]) * NEED_W'(req_count_reg[DATA_W-2:0]);
    assign carve_sum = SUM_W'(bump_reg) + SUM_W'(need_reg) + SUM_W'(gap_reg);

    ffza_ram #(.WIDTH(DATA_W), .DEPTH(ZONE_ENTRIES)) u_base_ram (
        .clk     (clk),
        .wr_en   (cmd.commit_new),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (bump_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_base)
    );

    ffza_ram #(.WIDTH(DATA_W), .DEPTH(ZONE_ENTRIES)) u_length_ram (
        .clk     (clk),
        .wr_en   (cmd.commit_new),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (need_reg[DATA_W-1:0]),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_len)
    );

    always_comb
    begin
        stat.is_free     = req_func_reg;
        stat.bad_size    = req_size_reg[DATA_W-1];
        stat.bad_count   = req_count_reg[DATA_W-1];
        stat.empty_req   = (req_size_reg == '0) || (req_count_reg == '0);
        stat.addr_zero   = (req_addr_reg == '0);
        stat.table_empty = (count_reg == '0);
        stat.table_full  = (count_reg >= CNT_W'(ZONE_ENTRIES));
        stat.last        = (left_reg == CNT_W'(1));
        stat.fits        = (carve_sum <= SUM_W'(heap_end_reg));
        stat.slot_free   = !out_valid_reg || out_ready;
        if (req_func_reg)
        begin
            stat.hit = in_use_reg[chk_idx_reg] && (rd_base == req_addr_reg);
        end
        else
        begin
            stat.hit = !in_use_reg[chk_idx_reg] && (NEED_W'(rd_len) >= need_reg);
        end
    end

    always_comb
    begin
        heap_start_next = heap_start_reg;
        heap_end_next   = heap_end_reg;
        gap_next        = gap_reg;
        bump_next       = bump_reg;
        count_next      = count_reg;
        in_use_next     = in_use_reg;
        chk_idx_next    = chk_idx_reg;
        left_next       = left_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        granted_next    = granted_reg;
        status_next     = status_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HEAP_START:
                begin
                    heap_start_next = cfg_data & ADDR_MASK;
                    if (count_reg == '0)
                    begin
                        bump_next = cfg_data & ADDR_MASK;
                    end
                end
                CFG_HEAP_END: heap_end_next = cfg_data & ADDR_MASK;
                CFG_DESC_GAP: gap_next = cfg_data[GAP_W-1:0];
                default: ;
            endcase
        end

        if (cmd.scan_start)
        begin
            chk_idx_next = count_m1[IDX_W-1:0];
            left_next    = count_reg;
        end
        else if (cmd.scan_step)
        begin
            chk_idx_next = chk_idx_reg - IDX_W'(1);
            left_next    = left_reg - CNT_W'(1);
        end

        if (cmd.commit_hit)
        begin
            in_use_next[chk_idx_reg] = !req_func_reg;
        end

        if (cmd.commit_new)
        begin
            in_use_next[count_reg[IDX_W-1:0]] = 1'b1;
            count_next = count_reg + CNT_W'(1);
            bump_next  = carve_sum[DATA_W-1:0] & ADDR_MASK;
        end

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            status_next    = cmd.code;
            if (cmd.code == ST_REUSED)
            begin
                granted_next = rd_base;
            end
            else if (cmd.code == ST_NEW)
            begin
                granted_next = bump_reg;
            end
            else
            begin
                granted_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_start_reg <= '0;
            heap_end_reg   <= ADDR_MASK;
            gap_reg        <= GAP_RESET;
            bump_reg       <= '0;
            count_reg      <= '0;
            in_use_reg     <= '0;
            out_valid_reg  <= 1'b0;
            left_reg       <= '0;
        end
        else
        begin
            heap_start_reg <= heap_start_next;
            heap_end_reg   <= heap_end_next;
            gap_reg        <= gap_next;
            bump_reg       <= bump_next;
            count_reg      <= count_next;
            in_use_reg     <= in_use_next;
            out_valid_reg  <= out_valid_next;
            left_reg       <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_func_reg  <= func;
            req_size_reg  <= element_size;
            req_count_reg <= element_count;
            req_addr_reg  <= zone_address & ADDR_MASK;
        end
        if (cmd.load_need)
        begin
            need_reg <= need_next;
        end
        chk_idx_reg <= chk_idx_next;
        granted_reg <= granted_next;
        status_reg  <= status_next;
    end

    assign out_valid       = out_valid_reg;
    assign granted_address = granted_reg;
    assign status          = status_reg;

endmodule

`default_nettype wire

// ===== rtl/first_fit_zone_allocator.sv =====
// sequence: a request rejected by its size or count checks, or a free of address zero
//   or into an empty table, is answered from the check; otherwise the table is scanned
//   newest first, and an alloc with no hit (or an empty table) carves a new zone
// requests: one at a time; the next is taken only after the last result is written to
//   the output register; the table scan reads one entry per cycle
// reset: rst_n asynchronous, active low; clears the in-use marks, zone count and bump
//   pointer and loads the register reset values; base and length memories are not cleared
`timescale 1ns / 1ps
`default_nettype none

module first_fit_zone_allocator
    import ffza_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // configuration write port
    input  wire logic              cfg_we,
    input  wire logic [CFG_W-1:0]  cfg_index,
    input  wire logic [DATA_W-1:0] cfg_data,
    // request channel
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              func,
    input  wire logic [DATA_W-1:0] element_size,
    input  wire logic [DATA_W-1:0] element_count,
    input  wire logic [DATA_W-1:0] zone_address,
    // result channel
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [DATA_W-1:0]      granted_address,
    output logic [STAT_W-1:0]      status
);

    ffza_cmd_t  cmd;
    ffza_stat_t stat;

    // controller: sequences check, newest-first scan and carve of one request
    ffza_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: config registers, zone table, bump pointer and result register
    ffza_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .func            (func),
        .element_size    (element_size),
        .element_count   (element_count),
        .zone_address    (zone_address),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .granted_address (granted_address),
        .status          (status)
    );

    // request beat is taken only while the controller is idle
    assign in_ready = cmd.in_ready;

    // a result is only written when the output slot is free or draining
    a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.slot_free)
        else $error("result written over a waiting beat");

    // a new zone never goes past the end of the table
    a_carve_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit_new |-> !stat.table_full)
        else $error("zone carved into a full table");

    // the scan never steps past the oldest entry
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> !stat.last && !stat.hit)
        else $error("scan stepped past its end");

    // only grants carry a nonzero address
    a_grant_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (granted_address != '0) |-> (status == ST_NEW) || (status == ST_REUSED))
        else $error("nonzero address on a non-grant result");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import ffza_pkg::*;

    // request opcodes and the register index that decodes to nothing
    localparam logic                OP_ALLOC  = 1'b0;
    localparam logic                OP_FREE   = 1'b1;
    localparam logic [CFG_W-1:0]    CFG_SPARE = 2'd3;
    localparam logic [DATA_W-1:0]   NO_ADDR   = '0;
    localparam int                  PHASES    = 8;
    localparam int                  PHASE_LEN = 250;

    // one request beat and one result beat
    typedef struct packed {
        logic              op;
        logic [DATA_W-1:0] size;
        logic [DATA_W-1:0] count;
        logic [DATA_W-1:0] addr;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0] addr;
        logic [STAT_W-1:0] code;
    } grant_t;

    // one row of the directed script: either a register write or a request,
    // with the result typed in where it is obvious
    typedef struct packed {
        logic              is_cfg;
        logic [CFG_W-1:0]  reg_idx;
        logic [DATA_W-1:0] reg_val;
        req_t              req;
        logic              typed;
        grant_t            want;
    } step_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [CFG_W-1:0]  cfg_index;
    logic [DATA_W-1:0] cfg_data;
    logic              in_valid;
    logic              in_ready;
    logic              func;
    logic [DATA_W-1:0] element_size;
    logic [DATA_W-1:0] element_count;
    logic [DATA_W-1:0] zone_address;
    logic              out_valid;
    logic              out_ready;
    logic [DATA_W-1:0] granted_address;
    logic [STAT_W-1:0] status;

    first_fit_zone_allocator u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .func            (func),
        .element_size    (element_size),
        .element_count   (element_count),
        .zone_address    (zone_address),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .granted_address (granted_address),
        .status          (status)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // shadow copy of the zone table, the bump pointer and the registers
    logic [DATA_W-1:0] shadow_base [ZONE_ENTRIES];
    logic [DATA_W-1:0] shadow_len  [ZONE_ENTRIES];
    logic              shadow_busy [ZONE_ENTRIES];
    int                shadow_zones;
    logic [DATA_W-1:0] shadow_bump;
    logic [DATA_W-1:0] reg_start;
    logic [DATA_W-1:0] reg_end;
    logic [GAP_W-1:0]  reg_gap;

    grant_t grants_due [$];
    step_t  script [$];

    int     mismatches;
    int     requests_sent;
    int     results_checked;
    int     code_hits [16];
    logic   no_idle;
    logic   backpressure_done;

    // --------------------------------------------------------------------
    // predictor: works out the result of one request and updates the shadow
    // --------------------------------------------------------------------
    function automatic grant_t predict_grant(input req_t r);
        logic [63:0]       need;
        logic [63:0]       next_bump;
        logic [DATA_W-1:0] addr;
        logic [DATA_W-1:0] granted;
        if (r.op == OP_FREE)
        begin
            addr = r.addr & ADDR_MASK;
            // a free of address zero never matches, not even the zone at zero
            if (addr == NO_ADDR)
                return {NO_ADDR, ST_NO_MATCH};
            // newest used zone with that base
            for (int k = shadow_zones - 1; k >= 0; k--)
            begin
                if (shadow_busy[k] && shadow_base[k] == addr)
                begin
                    shadow_busy[k] = 1'b0;
                    return {NO_ADDR, ST_FREED};
                end
            end
            return {NO_ADDR, ST_NO_MATCH};
        end
        // size is checked before count, sign before zero
        if (r.size[DATA_W-1])
            return {NO_ADDR, ST_BAD_SIZE};
        if (r.count[DATA_W-1])
            return {NO_ADDR, ST_BAD_COUNT};
        if (r.size == '0 || r.count == '0)
            return {NO_ADDR, ST_EMPTY};
        need = 64'(r.size) * 64'(r.count);
        // first fit, newest zone first
        for (int k = shadow_zones - 1; k >= 0; k--)
        begin
            if (!shadow_busy[k] && 64'(shadow_len[k]) >= need)
            begin
                shadow_busy[k] = 1'b1;
                return {shadow_base[k], ST_REUSED};
            end
        end
        // heap limit comes before the table check, and nothing moves on either
        next_bump = 64'(shadow_bump) + need + 64'(reg_gap);
        if (next_bump > 64'(reg_end))
            return {NO_ADDR, ST_NO_MEMORY};
        if (shadow_zones >= ZONE_ENTRIES)
            return {NO_ADDR, ST_TABLE_FULL};
        granted                   = shadow_bump;
        shadow_base[shadow_zones] = shadow_bump;
        shadow_len[shadow_zones]  = need[DATA_W-1:0];
        shadow_busy[shadow_zones] = 1'b1;
        shadow_zones++;
        shadow_bump = next_bump[DATA_W-1:0] & ADDR_MASK;
        return {granted, ST_NEW};
    endfunction

    // idle length for either side: mostly none, sometimes a few, rarely long
    function automatic int pick_idle();
        int unsigned roll;
        if (no_idle)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // random request: mostly sane allocs and frees of table bases, some noise
    function automatic req_t pick_request();
        req_t        r;
        int unsigned roll;
        r.op    = OP_ALLOC;
        r.size  = $urandom;
        r.count = $urandom;
        r.addr  = $urandom;
        roll    = $urandom_range(0, 99);
        if (roll < 50)
        begin
            r.size  = $urandom_range(1, 64);
            r.count = $urandom_range(1, 16);
            if ($urandom_range(0, 9) == 0)
                r.size = $urandom_range(1, 65536);
        end
        else if (roll < 80)
        begin
            r.op = OP_FREE;
            if (shadow_zones > 0 && $urandom_range(0, 5) != 0)
                r.addr = shadow_base[$urandom_range(0, shadow_zones - 1)];
            else if ($urandom_range(0, 1) == 0)
                r.addr = NO_ADDR;
        end
        else if (roll < 86)
        begin
            // empty requests, either field zero
            if ($urandom_range(0, 1) == 0)
                r.size = '0;
            else
                r.count = '0;
        end
        // otherwise fully random size and count: negatives and huge products
        return r;
    endfunction

    function automatic void script_cfg(input logic [CFG_W-1:0] idx,
                                       input logic [DATA_W-1:0] val);
        step_t s;
        s         = '0;
        s.is_cfg  = 1'b1;
        s.reg_idx = idx;
        s.reg_val = val;
        script.push_back(s);
    endfunction

    function automatic void script_req(input logic op, input logic [DATA_W-1:0] size,
                                       input logic [DATA_W-1:0] count,
                                       input logic [DATA_W-1:0] addr, input logic typed,
                                       input logic [DATA_W-1:0] want_addr,
                                       input logic [STAT_W-1:0] want_code);
        step_t s;
        s           = '0;
        s.req       = {op, size, count, addr};
        s.typed     = typed;
        s.want      = {want_addr, want_code};
        script.push_back(s);
    endfunction

    // --------------------------------------------------------------------
    // request side: idle, offer the beat, hold it until taken
    // --------------------------------------------------------------------
    task automatic send(input req_t r, input int idle, input logic typed,
                        input grant_t want);
        grant_t got;
        if (idle > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (idle - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid      <= 1'b1;
        func          <= r.op;
        element_size  <= r.size;
        element_count <= r.count;
        zone_address  <= r.addr;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        // the beat is taken at this edge; the block works in order, so
        // predicting now keeps the shadow in step
        got = predict_grant(r);
        grants_due.push_back(typed ? want : got);
        requests_sent++;
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (grants_due.size() != 0)
            @(posedge clk);
    endtask

    // register write, only ever issued with the block idle
    task automatic write_reg(input logic [CFG_W-1:0] idx, input logic [DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_HEAP_START:
            begin
                reg_start = val & ADDR_MASK;
                // bump pointer follows heap_start only while no zone exists
                if (shadow_zones == 0)
                    shadow_bump = reg_start;
            end
            CFG_HEAP_END: reg_end = val & ADDR_MASK;
            CFG_DESC_GAP: reg_gap = val[GAP_W-1:0];
            default: ;
        endcase
    endtask

    // --------------------------------------------------------------------
    // result side: random ready, plus one long hold-off to back the block up
    // --------------------------------------------------------------------
    initial
    begin : result_sink
        int hold_left;
        hold_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
                hold_left--;
            else if (!backpressure_done && results_checked >= 800)
            begin
                // long stall while the sender keeps offering
                out_ready        <= 1'b0;
                hold_left         = 400;
                backpressure_done = 1'b1;
            end
            else
            begin
                hold_left = pick_idle();
                out_ready <= (hold_left == 0);
            end
        end
    end

    // result checker: every beat against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (grants_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: addr %h status %0d",
                             granted_address, status);
            end
            else
            begin : compare_beat
                grant_t exp;
                exp = grants_due.pop_front();
                if (granted_address !== exp.addr || status !== exp.code)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: expected addr %h status %0d, got addr %h status %0d",
                                 results_checked, exp.addr, exp.code, granted_address,
                                 status);
                end
            end
            code_hits[status]++;
            results_checked++;
        end
    end

    // hard limit on the whole run
    initial
    begin
        #10_000_000;
        $display("timeout with %0d results outstanding", grants_due.size());
        $display("== FAIL ==");
        $finish;
    end

    // --------------------------------------------------------------------
    // main sequence
    // --------------------------------------------------------------------
    initial
    begin
        logic [63:0] roomy;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_HEAP_START;
        cfg_data          = '0;
        in_valid          = 1'b0;
        func              = OP_ALLOC;
        element_size      = '0;
        element_count     = '0;
        zone_address      = '0;
        no_idle           = 1'b0;
        backpressure_done = 1'b0;
        mismatches        = 0;
        requests_sent     = 0;
        results_checked   = 0;
        foreach (code_hits[i])
            code_hits[i] = 0;

        // shadow reset state
        reg_start    = '0;
        reg_end      = '1 & ADDR_MASK;
        reg_gap      = GAP_RESET;
        shadow_zones = 0;
        shadow_bump  = '0;
        foreach (shadow_busy[i])
            shadow_busy[i] = 1'b0;

        // directed script
        // heap_start reloads the bump pointer while the table is empty
        script_cfg(CFG_HEAP_START, 32'h0000_0100);
        script_cfg(CFG_SPARE, 32'hDEAD_BEEF);
        script_cfg(CFG_HEAP_START, 32'h0000_0000);
        // first zone lands at address zero and can never be freed
        script_req(OP_ALLOC, 1, 1, 0, 1, NO_ADDR, ST_NEW);
        script_req(OP_FREE, 0, 0, 0, 1, NO_ADDR, ST_NO_MATCH);
        // argument checks and their order
        script_req(OP_ALLOC, 32'h8000_0000, 1, 0, 1, NO_ADDR, ST_BAD_SIZE);
        script_req(OP_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1, NO_ADDR, ST_BAD_SIZE);
        script_req(OP_ALLOC, 0, 32'h8000_0000, 0, 1, NO_ADDR, ST_BAD_COUNT);
        script_req(OP_ALLOC, 0, 7, 0, 1, NO_ADDR, ST_EMPTY);
        script_req(OP_ALLOC, 7, 0, 0, 1, NO_ADDR, ST_EMPTY);
        // product far beyond 32 bits
        script_req(OP_ALLOC, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 1, NO_ADDR, ST_NO_MEMORY);
        // bump sits at 25: a 40 byte zone plus gap ends exactly on heap_end
        script_cfg(CFG_HEAP_END, 89);
        script_req(OP_ALLOC, 8, 5, 0, 1, 25, ST_NEW);
        script_req(OP_ALLOC, 1, 1, 0, 1, NO_ADDR, ST_NO_MEMORY);
        script_req(OP_FREE, 0, 0, 25, 1, NO_ADDR, ST_FREED);
        script_req(OP_FREE, 0, 0, 25, 1, NO_ADDR, ST_NO_MATCH);
        // exact length reuse
        script_req(OP_ALLOC, 4, 10, 0, 1, 25, ST_REUSED);
        script_req(OP_ALLOC, 41, 1, 0, 0, NO_ADDR, ST_NEW);
        script_cfg(CFG_HEAP_END, 32'hFFFF_FFFF);
        script_cfg(CFG_DESC_GAP, 0);
        script_req(OP_ALLOC, 3, 3, 0, 0, NO_ADDR, ST_NEW);
        script_cfg(CFG_DESC_GAP, 255);
        script_req(OP_ALLOC, 1, 32'h7FFF_FFFF, 0, 0, NO_ADDR, ST_NEW);
        script_req(OP_FREE, 0, 0, 98, 0, NO_ADDR, ST_NEW);
        script_req(OP_FREE, 0, 0, 32'hFFFF_FFFF, 1, NO_ADDR, ST_NO_MATCH);
        // table not empty: the bump pointer stays put
        script_cfg(CFG_HEAP_START, 32'h0000_4000);
        script_req(OP_ALLOC, 2, 2, 0, 0, NO_ADDR, ST_NEW);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
        begin
            if (script[i].is_cfg)
            begin
                drain();
                write_reg(script[i].reg_idx, script[i].reg_val);
            end
            else
                send(script[i].req, pick_idle(), script[i].typed, script[i].want);
        end

        // random phases, each with its own register setting
        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            no_idle = 1'b0;
            case (p)
                0:
                begin
                    // back-to-back beats on both sides
                    write_reg(CFG_DESC_GAP, GAP_RESET);
                    no_idle = 1'b1;
                end
                1: write_reg(CFG_DESC_GAP, 0);
                2:
                begin
                    // heap limit just above the bump pointer
                    write_reg(CFG_DESC_GAP, 255);
                    roomy = 64'(shadow_bump) + 64'($urandom_range(0, 3000));
                    write_reg(CFG_HEAP_END, roomy > 64'hFFFF_FFFF ? '1 : roomy[DATA_W-1:0]);
                end
                3:
                begin
                    write_reg(CFG_HEAP_END, 32'hFFFF_FFFF);
                    write_reg(CFG_HEAP_START, $urandom);
                    write_reg(CFG_DESC_GAP, $urandom_range(0, 255));
                end
                4:
                begin
                    // extremes: nothing new fits anywhere
                    write_reg(CFG_HEAP_START, 32'hFFFF_FFFF);
                    write_reg(CFG_HEAP_END, 32'h0000_0000);
                    write_reg(CFG_DESC_GAP, GAP_RESET);
                end
                5:
                begin
                    write_reg(CFG_HEAP_END, 32'hFFFF_FFFF);
                    write_reg(CFG_DESC_GAP, $urandom_range(0, 255));
                    no_idle = 1'b1;
                end
                6:
                begin
                    write_reg(CFG_DESC_GAP, 0);
                    roomy = 64'(shadow_bump) + 64'($urandom_range(0, 500));
                    write_reg(CFG_HEAP_END, roomy > 64'hFFFF_FFFF ? '1 : roomy[DATA_W-1:0]);
                end
                default:
                begin
                    write_reg(CFG_HEAP_START, $urandom);
                    write_reg(CFG_HEAP_END, $urandom);
                    write_reg(CFG_DESC_GAP, $urandom);
                    write_reg(CFG_SPARE, $urandom);
                end
            endcase
            repeat (PHASE_LEN)
                send(pick_request(), pick_idle(), 1'b0, '0);
        end

        drain();
        // let any stray beat show up before judging
        repeat (80) @(posedge clk);
        mismatches += grants_due.size();

        $display("%0d requests, %0d results: %0d new, %0d reused, %0d freed, %0d no match",
                 requests_sent, results_checked, code_hits[ST_NEW], code_hits[ST_REUSED],
                 code_hits[ST_FREED], code_hits[ST_NO_MATCH]);
        $display("rejects: %0d size, %0d count, %0d empty, %0d heap, %0d table; %0d mismatches",
                 code_hits[ST_BAD_SIZE], code_hits[ST_BAD_COUNT], code_hits[ST_EMPTY],
                 code_hits[ST_NO_MEMORY], code_hits[ST_TABLE_FULL], mismatches);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== first_fit_zone_allocator.f =====
rtl/ffza_pkg.sv
rtl/ffza_ram.sv
rtl/ffza_ctrl.sv
rtl/ffza_dp.sv
rtl/first_fit_zone_allocator.sv
bench/testbench.sv
